// File: rtl/sipq_pkg.sv
// ============================================================================
// sipq_pkg
// Shared types, codes and the priority-to-level map of the soft interrupt
// priority queue.
// ============================================================================
package sipq_pkg;

	localparam int ID_W       = 6;
	localparam int PRI_W      = 8;
	localparam int NUM_LEVELS = 5;
	localparam int LEVEL_W    = 3;
	localparam int PRI_BIAS   = 32;
	localparam int PRI_SHIFT  = 4;
	localparam int TOP_LEVEL  = 4;

	// func field codes
	localparam logic FUNC_POST = 1'b0;
	localparam logic FUNC_TAKE = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_TAKE
	} ctrl_state_t;

	// controller -> datapath commands
	typedef struct packed {
		logic post_en;     // post word accepted, update lists and load result
		logic take_rd;     // take word accepted, fetch link of top head
		logic take_commit; // pop top head and load result
	} dp_cmd_t;

	// (pri + bias) >> shift, clamped to 0..TOP_LEVEL
	function automatic logic [LEVEL_W-1:0] pick_level(input logic signed [PRI_W-1:0] pri);
		logic signed [PRI_W:0] biased;
		logic [PRI_W-PRI_SHIFT-1:0] shifted;
		biased  = {pri[PRI_W-1], pri} + (PRI_W+1)'(PRI_BIAS);
		shifted = biased[PRI_W-1:PRI_SHIFT];
		if (biased[PRI_W])
			return '0;
		else if (shifted > (PRI_W-PRI_SHIFT)'(TOP_LEVEL))
			return LEVEL_W'(TOP_LEVEL);
		else
			return LEVEL_W'(shifted);
	endfunction

endpackage

// File: rtl/soft_interrupt_priority_queue_top.sv
// Soft interrupt priority queue. A post word (func = 0) queues int_id on one
// of five levels picked by (priority_req + 32) >> 4, clamped to 0..4; a post
// of an id that is already queued, or an id at or above NUM_INTS, is dropped
// with accepted = 0. A take word (func = 1) pops the oldest entry of the
// highest non-empty level and returns it on granted_id / granted_level with
// granted_valid = 1, or granted_valid = 0 when nothing is queued. Every word
// in gives exactly one word out; pending reports whether anything is still
// queued after that word. A take has a second step: the successor
// link of the popped head comes out of the link memory, whose read port is
// registered, in the cycle after the take is accepted. Results sit in a single
// output register, so a new word is only taken once that register is empty
// or its word leaves on out_ready in the same cycle; a waiting result stalls
// the input. The queue is empty after reset; no clearing pass is needed.
// ============================================================================
// soft_interrupt_priority_queue_top
// Five-level FIFO queue of software interrupts: sequencer plus datapath.
// ============================================================================
module soft_interrupt_priority_queue_top #(
	parameter int NUM_INTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input words
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [sipq_pkg::ID_W-1:0]           int_id,
	input  logic signed [sipq_pkg::PRI_W-1:0]   priority_req,
	// result words
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                accepted,
	output logic                                granted_valid,
	output logic [sipq_pkg::ID_W-1:0]           granted_id,
	output logic [sipq_pkg::LEVEL_W-1:0]        granted_level,
	output logic                                pending
);
	import sipq_pkg::*;

	dp_cmd_t cmd;

	// handshake and take sequencing
	sipq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.func      (func),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// lists, marks, link memory, result register
	sipq_dp #(
		.NUM_INTS (NUM_INTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.int_id        (int_id),
		.priority_req  (priority_req),
		.accepted      (accepted),
		.granted_valid (granted_valid),
		.granted_id    (granted_id),
		.granted_level (granted_level),
		.pending       (pending)
	);

endmodule

// File: rtl/sipq_ctrl.sv
// ============================================================================
// sipq_ctrl
// Sequencer: input/output handshake, take fetch state, output valid.
// ============================================================================
module sipq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              func,
	input  logic              out_ready,
	output logic              in_ready,
	output logic              out_valid,
	output sipq_pkg::dp_cmd_t cmd
);
	import sipq_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;
	logic        accept;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_TAKE)
					state_d = ST_TAKE;
			end
			ST_TAKE: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.post_en = accept && func == FUNC_POST;
				cmd.take_rd = accept && func == FUNC_TAKE;
			end
			ST_TAKE: begin
				cmd.take_commit = slot_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.post_en || cmd.take_commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_take_enters_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_rd |=> state_q == ST_TAKE)
		else $error("take accepted without entering fetch state");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.post_en || cmd.take_commit))
		else $error("output valid raised without a result load");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.post_en || cmd.take_commit) |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken word");

endmodule

// File: rtl/sipq_dp.sv
// ============================================================================
// sipq_dp
// Datapath: queued marks, per-level head/tail lists, link memory and the
// result register.
// ============================================================================
module sipq_dp #(
	parameter int NUM_INTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sipq_pkg::dp_cmd_t                   cmd,
	input  logic [sipq_pkg::ID_W-1:0]           int_id,
	input  logic signed [sipq_pkg::PRI_W-1:0]   priority_req,
	output logic                                accepted,
	output logic                                granted_valid,
	output logic [sipq_pkg::ID_W-1:0]           granted_id,
	output logic [sipq_pkg::LEVEL_W-1:0]        granted_level,
	output logic                                pending
);
	import sipq_pkg::*;

	// only ids that fit the id field can ever be stored
	localparam int ID_SPAN = 1 << ID_W;
	localparam int DEPTH   = (NUM_INTS < ID_SPAN) ? NUM_INTS : ID_SPAN;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DEPTH-1:0]      mark_q;
	logic [IDX_W-1:0]      head_q [NUM_LEVELS];
	logic [IDX_W-1:0]      tail_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] nonempty_q;
	logic [IDX_W-1:0]      link_mem [DEPTH];
	logic [IDX_W-1:0]      link_rd_q;

	logic                  accepted_q;
	logic                  granted_valid_q;
	logic [ID_W-1:0]       granted_id_q;
	logic [LEVEL_W-1:0]    granted_level_q;
	logic                  pending_q;

	logic                  id_ok;
	logic [IDX_W-1:0]      id_idx;
	logic [LEVEL_W-1:0]    post_lvl;
	logic                  post_ok;
	logic                  top_found;
	logic [LEVEL_W-1:0]    top_lvl;
	logic [IDX_W-1:0]      top_head;
	logic                  top_last;
	logic [NUM_LEVELS-1:0] take_ne;

	// post side
	assign id_ok    = 32'(int_id) < 32'(NUM_INTS);
	assign id_idx   = int_id[IDX_W-1:0];
	assign post_lvl = pick_level(priority_req);
	assign post_ok  = id_ok && !mark_q[id_idx];

	// take side: highest non-empty level
	always_comb begin
		top_found = 1'b0;
		top_lvl   = '0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (nonempty_q[l]) begin
				top_found = 1'b1;
				top_lvl   = LEVEL_W'(l);
			end
		end
	end

	assign top_head = head_q[top_lvl];
	assign top_last = top_head == tail_q[top_lvl];

	always_comb begin
		take_ne = nonempty_q;
		if (top_found && top_last)
			take_ne[top_lvl] = 1'b0;
	end

	// list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q     <= '0;
			nonempty_q <= '0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
			end
		end else if (cmd.post_en && post_ok) begin
			if (!nonempty_q[post_lvl]) begin
				head_q[post_lvl]     <= id_idx;
				nonempty_q[post_lvl] <= 1'b1;
			end
			tail_q[post_lvl] <= id_idx;
			mark_q[id_idx]   <= 1'b1;
		end else if (cmd.take_commit && top_found) begin
			if (top_last)
				nonempty_q[top_lvl] <= 1'b0;
			else
				head_q[top_lvl] <= link_rd_q;
			mark_q[top_head] <= 1'b0;
		end
	end

	// link memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.post_en && post_ok && nonempty_q[post_lvl])
			link_mem[tail_q[post_lvl]] <= id_idx;
		if (cmd.take_rd)
			link_rd_q <= link_mem[top_head];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.post_en) begin
			accepted_q      <= post_ok;
			granted_valid_q <= 1'b0;
			granted_id_q    <= '0;
			granted_level_q <= '0;
			pending_q       <= (nonempty_q != '0) || post_ok;
		end else if (cmd.take_commit) begin
			accepted_q      <= 1'b0;
			granted_valid_q <= top_found;
			granted_id_q    <= top_found ? ID_W'(top_head) : '0;
			granted_level_q <= top_found ? top_lvl : '0;
			pending_q       <= take_ne != '0;
		end
	end

	assign accepted      = accepted_q;
	assign granted_valid = granted_valid_q;
	assign granted_id    = granted_id_q;
	assign granted_level = granted_level_q;
	assign pending       = pending_q;

	a_marks_match_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(nonempty_q == '0) == (mark_q == '0))
		else $error("queued marks disagree with level occupancy");

	a_top_head_marked: assert property (@(posedge clk) disable iff (!arst_n)
		top_found |-> mark_q[top_head])
		else $error("head of a non-empty level is not marked queued");

	a_pop_clears_mark: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_commit && top_found |=> !mark_q[$past(top_head)])
		else $error("popped interrupt still marked queued");

endmodule
